/* hdl/hrrp_pkg.sv */
// Shared constants, codes and types of the health-tracked round-robin picker.
package hrrp_pkg;

  localparam int NODES  = 16;
  localparam int SLOT_W = 4;
  localparam int CNT_W  = 5;
  localparam int TIME_W = 48;
  localparam int IV_W   = 16;
  localparam int CFG_W  = 2;
  localparam int STAMP_ADDR_W = SLOT_W + 1;

  localparam logic [IV_W-1:0] ALIVE_IV_RST = 16'd5000;
  localparam logic [IV_W-1:0] DEAD_IV_RST  = 16'd15000;

  // Which stamp bank an entry belongs to.
  localparam logic STAMP_OK   = 1'b0;
  localparam logic STAMP_FAIL = 1'b1;

  typedef enum logic [1:0] {
    REQ_POLL  = 2'd0,
    REQ_CHECK = 2'd1,
    REQ_PICK  = 2'd2
  } req_t;

  typedef enum logic [CFG_W-1:0] {
    CFG_PRESENT  = 2'd0,
    CFG_ALIVE_IV = 2'd1,
    CFG_DEAD_IV  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FIN
  } state_t;

  // Write and read requests toward the stamp memory.
  typedef struct packed {
    logic                    wr_en;
    logic [STAMP_ADDR_W-1:0] wr_addr;
    logic [TIME_W-1:0]       wr_data;
    logic                    rd_en;
    logic [STAMP_ADDR_W-1:0] rd_addr;
  } stamp_req_t;

endpackage

/* hdl/hrrp_in_if.sv */
// Input channel of the picker: one request item.
interface hrrp_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic [hrrp_pkg::SLOT_W-1:0]  node_index;
  logic                         check_ok;
  logic [hrrp_pkg::TIME_W-1:0]  now_ms;

  modport source (output valid, req_type, node_index, check_ok, now_ms, input ready);
  modport sink   (input valid, req_type, node_index, check_ok, now_ms, output ready);
endinterface

/* hdl/hrrp_out_if.sv */
// Result channel of the picker: one result item per request.
interface hrrp_out_if;
  logic                         valid;
  logic                         ready;
  logic [hrrp_pkg::NODES-1:0]   due_mask;
  logic [hrrp_pkg::CNT_W-1:0]   alive_count;
  logic                         state_changed;
  logic                         pick_valid;
  logic [hrrp_pkg::SLOT_W-1:0]  picked_node;
  logic                         request_error;

  modport source (output valid, due_mask, alive_count, state_changed, pick_valid,
                  picked_node, request_error, input ready);
  modport sink   (input valid, due_mask, alive_count, state_changed, pick_valid,
                  picked_node, request_error, output ready);
endinterface

/* hdl/hrrp_cfg_if.sv */
// Configuration write channel of the picker.
interface hrrp_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [hrrp_pkg::CFG_W-1:0]  index;
  logic [hrrp_pkg::IV_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/hrrp_stamp_mem.sv */
// Time stamp memory: last success and last failure time of every slot.
module hrrp_stamp_mem (
  input  logic                                clk,
  input  logic                                rst_n,
  input  hrrp_pkg::stamp_req_t                req,
  output logic [hrrp_pkg::TIME_W-1:0]         rd_data_r
);

  localparam int DEPTH = 2 * hrrp_pkg::NODES;

  logic [hrrp_pkg::TIME_W-1:0] mem [DEPTH];
  // An entry never written reads as zero, which means never.
  logic [DEPTH-1:0]            vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= vld_r[req.rd_addr] ? mem[req.rd_addr] : '0;
    end
  end

endmodule

/* hdl/hrrp_due_cmp.sv */
// Shared recheck comparator: stamp is never, or stamp plus interval lies before now.
module hrrp_due_cmp (
  input  logic [hrrp_pkg::TIME_W-1:0] stamp,
  input  logic [hrrp_pkg::IV_W-1:0]   interval,
  input  logic [hrrp_pkg::TIME_W-1:0] now,
  output logic                        due
);

  logic [hrrp_pkg::TIME_W:0] limit;

  // One bit wider so the sum never wraps.
  assign limit = {1'b0, stamp} + {{(hrrp_pkg::TIME_W + 1 - hrrp_pkg::IV_W){1'b0}}, interval};
  assign due   = (stamp == '0) || (limit < {1'b0, now});

endmodule

/* hdl/health_tracked_round_robin_picker.sv */
// Top level of the health-tracked round-robin picker: sequencer, slot sweep and result register.
//
//   Channel  Direction  Payload                                       Handshake
//   in_ch    in         req_type, node_index, check_ok, now_ms        valid / ready
//   out_ch   out        due_mask, alive_count, state_changed,         valid / ready
//                       pick_valid, picked_node, request_error
//   cfg_ch   in         index, data                                   valid / ready (always ready)
//
// Each item is accepted in the idle state; a sweep reads every slot's stamp in turn, a last step
// retires the last slot through the shared comparator, and the final state loads the result
// register before a new item is taken; the single stamp read port and one comparator set this
// order. Reset, synchronous and active low, clears the alive marks, pick pointer, stamp valid
// bits and present mask and restores the default intervals. A stalled result holds in the result
// register while the next item is accepted; a second waits in the final state until it drains.
module health_tracked_round_robin_picker (
  input  logic      clk,
  input  logic      rst_n,
  hrrp_in_if.sink   in_ch,
  hrrp_out_if.source out_ch,
  hrrp_cfg_if.sink  cfg_ch
);

  localparam int NODES  = hrrp_pkg::NODES;
  localparam int SLOT_W = hrrp_pkg::SLOT_W;
  localparam int CNT_W  = hrrp_pkg::CNT_W;
  localparam int TIME_W = hrrp_pkg::TIME_W;
  localparam int IV_W   = hrrp_pkg::IV_W;

  // Configuration registers.
  logic [NODES-1:0] present_r;
  logic [IV_W-1:0]  alive_iv_r;
  logic [IV_W-1:0]  dead_iv_r;

  // Health and pick state.
  logic [NODES-1:0]  alive_r;
  logic              last_vld_r;
  logic [SLOT_W-1:0] last_slot_r;

  // Per-item context.
  logic [1:0]        req_r;
  logic [TIME_W-1:0] now_r;
  logic [SLOT_W-1:0] start_r;
  logic              changed_r;
  logic              err_r;

  // Sequencer.
  hrrp_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r;

  // Sweep stage that waits on the registered stamp read.
  logic              s1_vld_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic              s1_alive_r;
  logic              s1_present_r;

  // Accumulated results.
  logic [NODES-1:0]  due_acc_r;
  logic [CNT_W-1:0]  cnt_acc_r;
  logic              pick_found_r;
  logic [SLOT_W-1:0] pick_slot_r;

  // Result register.
  logic              out_vld_r;
  logic [NODES-1:0]  out_due_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic              out_changed_r;
  logic              out_pvld_r;
  logic [SLOT_W-1:0] out_pnode_r;
  logic              out_err_r;

  logic                 in_acc;
  logic                 in_ready;
  logic                 is_check;
  logic                 chk_present;
  logic                 issue;
  logic                 sweep_done;
  logic                 out_free;
  logic                 out_load;
  logic [SLOT_W-1:0]    slot_cur;
  logic [TIME_W-1:0]    stamp;
  logic                 due;
  hrrp_pkg::stamp_req_t mem_req;

  assign in_acc      = in_ch.valid && in_ready;
  assign is_check    = (in_ch.req_type == hrrp_pkg::REQ_CHECK);
  assign chk_present = present_r[in_ch.node_index];
  assign slot_cur    = start_r + cnt_r[SLOT_W-1:0];
  assign issue       = (state_r == hrrp_pkg::ST_SWEEP) && (cnt_r < CNT_W'(NODES));
  assign sweep_done  = (state_r == hrrp_pkg::ST_SWEEP) && (cnt_r == CNT_W'(NODES));
  assign out_free    = !out_vld_r || out_ch.ready;

  // Configuration writes: the port is always ready, and indexes past the list are dropped.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r  <= '0;
      alive_iv_r <= hrrp_pkg::ALIVE_IV_RST;
      dead_iv_r  <= hrrp_pkg::DEAD_IV_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        hrrp_pkg::CFG_PRESENT:  present_r  <= cfg_ch.data;
        hrrp_pkg::CFG_ALIVE_IV: alive_iv_r <= cfg_ch.data;
        hrrp_pkg::CFG_DEAD_IV:  dead_iv_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // A check result on a present slot updates its alive mark and stamp at acceptance, so the
  // sweep that follows already sees the new state when it counts live slots.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r <= '0;
    end else if (in_acc && is_check && chk_present) begin
      alive_r[in_ch.node_index] <= in_ch.check_ok;
    end
  end

  always_comb begin
    mem_req.wr_en   = in_acc && is_check && chk_present;
    mem_req.wr_addr = {in_ch.check_ok ? hrrp_pkg::STAMP_OK : hrrp_pkg::STAMP_FAIL,
                       in_ch.node_index};
    mem_req.wr_data = in_ch.now_ms;
    mem_req.rd_en   = issue;
    // A live slot is judged by its last success, a dead one by its last failure.
    mem_req.rd_addr = {alive_r[slot_cur] ? hrrp_pkg::STAMP_OK : hrrp_pkg::STAMP_FAIL, slot_cur};
  end

  hrrp_stamp_mem u_stamp_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (mem_req),
    .rd_data_r (stamp)
  );

  hrrp_due_cmp u_due_cmp (
    .stamp    (stamp),
    .interval (s1_alive_r ? alive_iv_r : dead_iv_r),
    .now      (now_r),
    .due      (due)
  );

  // Item context captured at acceptance. A pick after an earlier pick that found a slot starts one
  // past the previous slot; otherwise the sweep starts at slot 0. The 16-slot ring covers every slot
  // once either way, and the previous slot comes last.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r     <= in_ch.req_type;
      now_r     <= in_ch.now_ms;
      start_r   <= (in_ch.req_type == hrrp_pkg::REQ_PICK && last_vld_r) ?
                   last_slot_r + SLOT_W'(1) : '0;
      changed_r <= is_check && chk_present && (alive_r[in_ch.node_index] != in_ch.check_ok);
      err_r     <= is_check && !chk_present;
    end
  end

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hrrp_pkg::ST_IDLE:  if (in_acc) state_nxt = hrrp_pkg::ST_SWEEP;
      hrrp_pkg::ST_SWEEP: if (sweep_done) state_nxt = hrrp_pkg::ST_FIN;
      hrrp_pkg::ST_FIN:   if (out_free) state_nxt = hrrp_pkg::ST_IDLE;
      default:            state_nxt = hrrp_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state_r)
      hrrp_pkg::ST_IDLE: in_ready = 1'b1;
      hrrp_pkg::ST_FIN:  out_load = out_free;
      default: ;
    endcase
  end

  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= hrrp_pkg::ST_IDLE;
      cnt_r    <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      s1_vld_r <= issue;
      if (in_acc) begin
        cnt_r <= '0;
      end else if (state_r == hrrp_pkg::ST_SWEEP) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_slot_r    <= slot_cur;
      s1_alive_r   <= alive_r[slot_cur];
      s1_present_r <= present_r[slot_cur];
    end
  end

  // Each slot retires in the cycle after its stamp read: a present slot is counted if alive,
  // marked due on a poll if due, and taken on a pick if it is the first live slot.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      due_acc_r    <= '0;
      cnt_acc_r    <= '0;
      pick_found_r <= 1'b0;
      pick_slot_r  <= '0;
    end else if (s1_vld_r && s1_present_r) begin
      if (s1_alive_r) begin
        cnt_acc_r <= cnt_acc_r + CNT_W'(1);
      end
      if (req_r == hrrp_pkg::REQ_POLL && due) begin
        due_acc_r[s1_slot_r] <= 1'b1;
      end
      if (req_r == hrrp_pkg::REQ_PICK && s1_alive_r && !pick_found_r) begin
        pick_found_r <= 1'b1;
        pick_slot_r  <= s1_slot_r;
      end
    end
  end

  // The pick pointer moves only when a live slot was found.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_vld_r  <= 1'b0;
      last_slot_r <= '0;
    end else if (out_load && pick_found_r) begin
      last_vld_r  <= 1'b1;
      last_slot_r <= pick_slot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_due_r     <= due_acc_r;
      out_cnt_r     <= cnt_acc_r;
      out_changed_r <= changed_r;
      out_pvld_r    <= pick_found_r;
      out_pnode_r   <= pick_slot_r;
      out_err_r     <= err_r;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.due_mask      = out_due_r;
  assign out_ch.alive_count   = out_cnt_r;
  assign out_ch.state_changed = out_changed_r;
  assign out_ch.pick_valid    = out_pvld_r;
  assign out_ch.picked_node   = out_pnode_r;
  assign out_ch.request_error = out_err_r;

`ifndef ASSERT_OFF
  // The sweep count must match the live slots when the result is loaded.
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (cnt_acc_r == CNT_W'($countones(present_r & alive_r))))
    else $error("alive count differs from the live slots");

  // A picked slot must be present and alive.
  a_pick_live: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && pick_found_r) |-> (present_r[pick_slot_r] && alive_r[pick_slot_r]))
    else $error("picked slot is not live");

  // Only present slots may be reported due.
  a_due_present: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> ((due_acc_r & ~present_r) == '0))
    else $error("due mask names an absent slot");
`endif

endmodule

/* sim/tb.sv */
// Self-checking testbench for the health-tracked round-robin picker.
`timescale 1ns / 1ps

module tb;
  import hrrp_pkg::*;

  localparam int  PHASES       = 8;
  localparam int  PHASE_ITEMS  = 197;
  localparam int  CYCLE_LIMIT  = 400000;
  localparam int  SETTLE_CYCLES = 40;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // One result item as the block reports it.
  typedef struct packed {
    logic [NODES-1:0]  due_mask;
    logic [CNT_W-1:0]  alive_count;
    logic              state_changed;
    logic              pick_valid;
    logic [SLOT_W-1:0] picked_node;
    logic              request_error;
  } slot_result_t;

  // Scoreboard: mirrors the slot health table and the pick pointer, and keeps the
  // queue of results that the block still owes.
  class health_scoreboard;
    logic [NODES-1:0]  present;
    logic [IV_W-1:0]   alive_iv;
    logic [IV_W-1:0]   dead_iv;
    bit   [NODES-1:0]  alive;
    logic [TIME_W-1:0] ok_stamp [NODES];
    logic [TIME_W-1:0] fail_stamp [NODES];
    bit                ptr_valid;
    logic [SLOT_W-1:0] ptr_slot;
    slot_result_t      owed [$];
    int                mismatches;
    int                compared;

    function new();
      present    = '0;
      alive_iv   = ALIVE_IV_RST;
      dead_iv    = DEAD_IV_RST;
      alive      = '0;
      ptr_valid  = 1'b0;
      ptr_slot   = '0;
      mismatches = 0;
      compared   = 0;
      for (int i = 0; i < NODES; i++) begin
        ok_stamp[i]   = '0;
        fail_stamp[i] = '0;
      end
    endfunction

    function void write_reg(cfg_idx_t idx, logic [IV_W-1:0] value);
      case (idx)
        CFG_PRESENT:  present  = value;
        CFG_ALIVE_IV: alive_iv = value;
        CFG_DEAD_IV:  dead_iv  = value;
        default: ;
      endcase
    endfunction

    // Applies one accepted request to the mirrored state and queues its result.
    function void note_request(req_t kind, logic [SLOT_W-1:0] slot, logic ok,
                               logic [TIME_W-1:0] now);
      slot_result_t      r;
      logic [TIME_W-1:0] last;
      logic [IV_W-1:0]   iv;
      bit                found;
      int                c;
      r = '0;
      found = 1'b0;
      case (kind)
        REQ_POLL: begin
          for (int i = 0; i < NODES; i++) begin
            if (present[i]) begin
              last = alive[i] ? ok_stamp[i] : fail_stamp[i];
              iv   = alive[i] ? alive_iv : dead_iv;
              // The sum is one bit wider than a stamp, so it never wraps.
              if (last == '0 || ({1'b0, last} + iv) < {1'b0, now})
                r.due_mask[i] = 1'b1;
            end
          end
        end
        REQ_CHECK: begin
          if (!present[slot]) begin
            r.request_error = 1'b1;
          end else begin
            r.state_changed = (alive[slot] != ok);
            alive[slot] = ok;
            if (ok)
              ok_stamp[slot] = now;
            else
              fail_stamp[slot] = now;
          end
        end
        REQ_PICK: begin
          for (int k = 0; k < NODES; k++) begin
            c = ptr_valid ? (ptr_slot + 1 + k) % NODES : k;
            if (!found && present[c] && alive[c]) begin
              found = 1'b1;
              r.pick_valid  = 1'b1;
              r.picked_node = c[SLOT_W-1:0];
            end
          end
          if (found) begin
            ptr_valid = 1'b1;
            ptr_slot  = r.picked_node;
          end
        end
        default: ;
      endcase
      for (int i = 0; i < NODES; i++)
        if (present[i] && alive[i])
          r.alive_count = r.alive_count + 1'b1;
      owed.push_back(r);
    endfunction

    function void check_result(slot_result_t got);
      slot_result_t want;
      if (owed.size() == 0) begin
        $error("unexpected result: due_mask %h alive_count %0d picked_node %0d",
               got.due_mask, got.alive_count, got.picked_node);
        mismatches++;
        return;
      end
      want = owed.pop_front();
      compared++;
      if (got.due_mask !== want.due_mask) begin
        $error("due_mask: expected %h, got %h", want.due_mask, got.due_mask);
        mismatches++;
      end
      if (got.alive_count !== want.alive_count) begin
        $error("alive_count: expected %0d, got %0d", want.alive_count, got.alive_count);
        mismatches++;
      end
      if (got.state_changed !== want.state_changed) begin
        $error("state_changed: expected %b, got %b", want.state_changed, got.state_changed);
        mismatches++;
      end
      if (got.pick_valid !== want.pick_valid) begin
        $error("pick_valid: expected %b, got %b", want.pick_valid, got.pick_valid);
        mismatches++;
      end
      if (got.picked_node !== want.picked_node) begin
        $error("picked_node: expected %0d, got %0d", want.picked_node, got.picked_node);
        mismatches++;
      end
      if (got.request_error !== want.request_error) begin
        $error("request_error: expected %b, got %b", want.request_error, got.request_error);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  hrrp_in_if  in_ch ();
  hrrp_out_if out_ch ();
  hrrp_cfg_if cfg_ch ();

  health_tracked_round_robin_picker dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  health_scoreboard sb = new();

  // Random idling is switched per phase so that some stretches run flat out.
  bit src_idle;
  bit snk_idle;
  int stall_left;
  int cycles;
  int n_poll, n_check, n_pick, n_settings;
  slot_result_t seen;

  always #6 clk = ~clk;

  // Timeout guard: the slowest legal run is far below this limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[health_tracked_round_robin_picker] ERROR");
      $finish;
    end
  end

  // Result side. Outputs are sampled at the edge, before the block updates them;
  // ready then drops for random bursts when stalls are enabled.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      seen.due_mask      = out_ch.due_mask;
      seen.alive_count   = out_ch.alive_count;
      seen.state_changed = out_ch.state_changed;
      seen.pick_valid    = out_ch.pick_valid;
      seen.picked_node   = out_ch.picked_node;
      seen.request_error = out_ch.request_error;
      sb.check_result(seen);
    end
    if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (snk_idle && $urandom_range(0, 4) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Presents one request item and returns at the edge where it is accepted.
  // Valid stays high on return so that back-to-back items need no second
  // assignment within one step; drain_results lowers it.
  task automatic send_req(req_t kind, logic [SLOT_W-1:0] slot, logic ok,
                          logic [TIME_W-1:0] now);
    if (src_idle && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= kind;
    in_ch.node_index <= slot;
    in_ch.check_ok   <= ok;
    in_ch.now_ms     <= now;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_request(kind, slot, ok, now);
    case (kind)
      REQ_POLL:  n_poll++;
      REQ_CHECK: n_check++;
      default:   n_pick++;
    endcase
  endtask

  // Stops the request stream and waits until every owed result has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [IV_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.write_reg(idx, value);
  endtask

  // Registers change only with the block idle. The three writes run back to
  // back with valid held high throughout.
  task automatic configure(logic [NODES-1:0] mask, logic [IV_W-1:0] alive_iv,
                           logic [IV_W-1:0] dead_iv);
    drain_results();
    write_reg(CFG_PRESENT, mask);
    write_reg(CFG_ALIVE_IV, alive_iv);
    write_reg(CFG_DEAD_IV, dead_iv);
    cfg_ch.valid <= 1'b0;
    n_settings++;
  endtask

  initial begin
    logic [TIME_W:0]   wall;
    logic [TIME_W-1:0] stamp;
    logic [NODES-1:0]  mask;
    logic [IV_W-1:0]   aiv;
    logic [IV_W-1:0]   div;
    int                step_max;
    int                ok_pct;
    int                roll;
    int                adv;
    req_t              kind;

    // Every input starts known, with reset held low.
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.req_type    <= REQ_POLL;
    in_ch.node_index  <= '0;
    in_ch.check_ok    <= 1'b0;
    in_ch.now_ms      <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= CFG_PRESENT;
    cfg_ch.data       <= '0;

    n_poll     = 0;
    n_check    = 0;
    n_pick     = 0;
    n_settings = 1;
    src_idle   = 1'b1;
    snk_idle   = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: no slot is present, so a check is refused and a pick
    // finds nothing.
    send_req(REQ_POLL, 4'd0, 1'b0, '0);
    send_req(REQ_CHECK, 4'd15, 1'b1, 48'd100);
    send_req(REQ_PICK, 4'd0, 1'b0, 48'd100);

    // All slots present with the default intervals. Slot 15 gets a stamp at
    // the top of the time range, so its due horizon must not wrap. Slots 3
    // and 9 get stamps of zero and must read as never checked.
    configure(16'hFFFF, ALIVE_IV_RST, DEAD_IV_RST);
    send_req(REQ_POLL, 4'd0, 1'b0, 48'd1);
    send_req(REQ_CHECK, 4'd0, 1'b1, 48'd1000);
    send_req(REQ_CHECK, 4'd15, 1'b1, TIME_MAX);
    send_req(REQ_CHECK, 4'd0, 1'b1, 48'd1000);
    send_req(REQ_CHECK, 4'd3, 1'b0, '0);
    send_req(REQ_CHECK, 4'd9, 1'b1, '0);
    send_req(REQ_CHECK, 4'd12, 1'b1, 48'd50);
    // The horizon of slot 0 is exactly 6000: due only strictly after it.
    send_req(REQ_POLL, 4'd0, 1'b0, 48'd6000);
    send_req(REQ_POLL, 4'd0, 1'b0, 48'd6001);
    // The first pick scans from slot 0; later picks go round and wrap.
    send_req(REQ_PICK, 4'd0, 1'b0, 48'd6001);
    send_req(REQ_PICK, 4'd0, 1'b0, 48'd6001);
    send_req(REQ_PICK, 4'd0, 1'b0, 48'd6001);
    send_req(REQ_PICK, 4'd0, 1'b0, 48'd6001);
    send_req(REQ_PICK, 4'd0, 1'b0, 48'd6001);
    // Kill every live slot: the pick finds none and the pointer must hold.
    send_req(REQ_CHECK, 4'd0, 1'b0, 48'd7000);
    send_req(REQ_CHECK, 4'd9, 1'b0, 48'd7000);
    send_req(REQ_CHECK, 4'd12, 1'b0, 48'd7000);
    send_req(REQ_CHECK, 4'd15, 1'b0, TIME_MAX - 48'd1);
    send_req(REQ_PICK, 4'd0, 1'b0, 48'd7000);
    // With one slot live again, a pick may return the previous slot.
    send_req(REQ_CHECK, 4'd12, 1'b1, 48'd7100);
    send_req(REQ_PICK, 4'd0, 1'b0, 48'd7100);
    send_req(REQ_PICK, 4'd0, 1'b0, 48'd7100);

    // Slot 12 leaves the set while marked alive: its mark is kept but no
    // longer counted or picked, and a check on it is refused.
    configure(16'h00FF, 16'd1, 16'hFFFF);
    send_req(REQ_PICK, 4'd0, 1'b0, 48'd7200);
    send_req(REQ_CHECK, 4'd12, 1'b1, 48'd7200);
    send_req(REQ_POLL, 4'd0, 1'b0, 48'd80000);

    // Random phases. Time mostly moves forward at a pace matched to the
    // intervals, so slots keep crossing their due horizons; a few requests
    // carry a random or zero time.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          mask = 16'hFFFF; aiv = 16'd1; div = 16'd1; step_max = 3;
          wall = 49'd1; src_idle = 1'b1; snk_idle = 1'b1;
        end
        1: begin
          mask = 16'hFFFF; aiv = 16'hFFFF; div = 16'hFFFF; step_max = 30000;
          wall = {1'b0, TIME_MAX} - 49'd400000; src_idle = 1'b1; snk_idle = 1'b1;
        end
        2: begin
          mask = 16'($urandom_range(0, 16'hFFFF)); aiv = 16'($urandom_range(1, 300));
          div = 16'($urandom_range(1, 300)); step_max = 100;
          wall = {1'b0, 48'({$urandom, $urandom})}; src_idle = 1'b1; snk_idle = 1'b0;
        end
        3: begin
          mask = 16'h8001; aiv = 16'd50; div = 16'd200; step_max = 60;
          wall = 49'd1; src_idle = 1'b0; snk_idle = 1'b1;
        end
        4: begin
          mask = 16'($urandom_range(0, 16'hFFFF)); aiv = 16'($urandom_range(1, 16'hFFFF));
          div = 16'($urandom_range(1, 16'hFFFF)); step_max = 40000;
          wall = {1'b0, 48'({$urandom, $urandom})}; src_idle = 1'b1; snk_idle = 1'b1;
        end
        5: begin
          mask = 16'($urandom_range(0, 16'hFFFF)); aiv = 16'($urandom_range(1, 100));
          div = 16'($urandom_range(1, 100)); step_max = 40;
          wall = 49'd1000; src_idle = 1'b1; snk_idle = 1'b1;
        end
        // The closing phases run with no idling on either side.
        6: begin
          mask = 16'hFFFF; aiv = 16'($urandom_range(1, 500));
          div = 16'($urandom_range(1, 500));
          step_max = 200; wall = 49'd5; src_idle = 1'b0; snk_idle = 1'b0;
        end
        default: begin
          mask = 16'($urandom_range(0, 16'hFFFF)); aiv = 16'($urandom_range(1, 1000));
          div = 16'($urandom_range(1, 1000)); step_max = 300;
          wall = {1'b0, 48'({$urandom, $urandom})}; src_idle = 1'b0; snk_idle = 1'b0;
        end
      endcase
      configure(mask, aiv, div);
      ok_pct = $urandom_range(30, 80);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        adv = $urandom_range(0, step_max);
        if (wall > {1'b0, TIME_MAX} - adv)
          wall = {1'b0, TIME_MAX};
        else
          wall = wall + adv;
        roll = $urandom_range(0, 99);
        if (roll < 5)
          stamp = 48'({$urandom, $urandom});
        else if (roll < 8)
          stamp = '0;
        else
          stamp = wall[TIME_W-1:0];
        roll = $urandom_range(0, 99);
        if (roll < 45)
          kind = REQ_CHECK;
        else if (roll < 72)
          kind = REQ_POLL;
        else
          kind = REQ_PICK;
        send_req(kind, 4'($urandom_range(0, NODES - 1)),
                 ($urandom_range(0, 99) < ok_pct), stamp);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d polls, %0d check results, %0d picks, under %0d settings.",
             n_poll + n_check + n_pick, n_poll, n_check, n_pick, n_settings);
    $display("Compared %0d results; %0d field mismatches or stray results; %0d still owed.",
             sb.compared, sb.mismatches, sb.owed.size());
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("[health_tracked_round_robin_picker] OK");
    end else begin
      $display("[health_tracked_round_robin_picker] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/hrrp_pkg.sv
hdl/hrrp_in_if.sv
hdl/hrrp_out_if.sv
hdl/hrrp_cfg_if.sv
hdl/hrrp_stamp_mem.sv
hdl/hrrp_due_cmp.sv
hdl/health_tracked_round_robin_picker.sv
sim/tb.sv
